// ----- sv/nhst_pkg.sv -----
// Shared types, constants and helpers for the neo-Hookean stress and tangent block.
package nhst_pkg;

	// Register indexes on the configuration port.
	localparam logic [0:0] CFG_LAMBDA = 1'b0;
	localparam logic [0:0] CFG_MU     = 1'b1;

	// ln 2 with 32 fraction bits.
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam int LOG_STEPS = 24;
	localparam int DIV_STEPS = 48;

	// One lane of the pipelined divider.
	typedef struct packed {
		logic        neg;
		logic        ovf;
		logic [30:0] rem;
		logic [47:0] quo;
		logic [23:0] ulo;
	} div_lane_t;

	// Saturate a 50-bit signed value to 48 bits.
	function automatic logic [47:0] sat48(input logic signed [49:0] v);
		logic [47:0] r;
		if (v > 50'sh0_7FFF_FFFF_FFFF) begin
			r = 48'h7FFF_FFFF_FFFF;
		end else if (v < -50'sh0_8000_0000_0000) begin
			r = 48'h8000_0000_0000;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/neo_hookean_stress_tangent.sv -----
// Compressible neo-Hookean Cauchy stress and tangent values, fully pipelined.
//
// Usage:
//   Requests arrive on the slave stream (s_tvalid, s_tready, s_tdata), one
//   deformation gradient and its determinant per request. Results leave on the
//   master stream (m_tvalid, m_tready, m_tdata), one per request, in order.
//   The Lame parameter and shear modulus are written through cfg_wen, cfg_addr
//   and cfg_wdata while no request is in flight.
// Pipeline and throughput:
//   A request passes from acceptance to the output register through two
//   product stages, 24 squaring stages of the log unit, five multiply and
//   add stages, 48 compare-subtract stages of the divider and the output
//   register. One request is accepted every cycle unless the output stalls.
// Reset:
//   arst_n clears all valid bits and both registers; no result is pending.
// Stall:
//   While a result waits and m_tready is low, the whole pipeline holds and
//   s_tready is low; nothing is lost or repeated.
module neo_hookean_stress_tangent (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [0:0]   cfg_addr,
	input  logic [39:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// f_xx, f_xy, f_xz, f_yx, f_yy, f_yz, f_zx, f_zy, f_zz, det_j (32 bits each)
	input  logic [319:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// sigma_xx, sigma_yy, sigma_zz, sigma_xy, sigma_yz, sigma_xz, tangent_diag,
	// tangent_shear (48 bits each), j_invalid (1 bit), 7 zero bits
	output logic [391:0] m_tdata
);

	localparam int NL = nhst_pkg::LOG_STEPS;
	localparam int ND = nhst_pkg::DIV_STEPS;

	// Row and column of each stress component.
	localparam int PI [6] = '{0, 1, 2, 0, 1, 0};
	localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};

	logic        en;
	logic [39:0] lam_q;
	logic [39:0] mu_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_q <= '0;
			mu_q  <= '0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				nhst_pkg::CFG_LAMBDA: lam_q <= cfg_wdata;
				nhst_pkg::CFG_MU:     mu_q  <= cfg_wdata;
				default:              ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: products of F rows and normalization of J.
	logic signed [31:0] f_in [9];
	logic signed [31:0] j_in;
	logic signed [47:0] pr_c [6][3];
	logic [4:0]         p_c;
	logic [30:0]        m_c;

	logic               vld_s1;
	logic               inv_s1;
	logic [30:0]        j_s1;
	logic signed [47:0] pr_s1 [6][3];
	logic [4:0]         p_s1;
	logic [30:0]        m_s1;

	always_comb begin
		logic signed [63:0] pw;
		for (int c = 0; c < 9; c++) begin
			f_in[c] = s_tdata[32*c +: 32];
		end
		j_in = s_tdata[288 +: 32];
		for (int c = 0; c < 6; c++) begin
			for (int k = 0; k < 3; k++) begin
				pw = f_in[PI[c]*3+k] * f_in[PJ[c]*3+k];
				if (pw < 0) begin
					pw = pw + 64'sd65535;
				end
				pr_c[c][k] = 48'(pw >>> 16);
			end
		end
		p_c = '0;
		for (int b = 0; b < 31; b++) begin
			if (j_in[b]) begin
				p_c = 5'(b);
			end
		end
		m_c = j_in[30:0] << (5'd30 - p_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s1 <= (j_in <= 0);
			j_s1   <= j_in[30:0];
			pr_s1  <= pr_c;
			p_s1   <= p_c;
			m_s1   <= m_c;
		end
	end

	// Stage 2 and the log chain: B sums, then one squaring per stage.
	logic               lg_vld_s [NL+1];
	logic               lg_inv_s [NL+1];
	logic [30:0]        lg_j_s   [NL+1];
	logic signed [50:0] lg_b_s   [NL+1][6];
	logic [4:0]         lg_p_s   [NL+1];
	logic [30:0]        lg_m_s   [NL+1];
	logic [23:0]        lg_fr_s  [NL+1];
	logic signed [50:0] b_c [6];
	logic [30:0]        lm_c  [NL];
	logic               lbit_c [NL];

	always_comb begin
		for (int c = 0; c < 6; c++) begin
			b_c[c] = 51'(pr_s1[c][0]) + 51'(pr_s1[c][1]) + 51'(pr_s1[c][2]);
			if (PI[c] == PJ[c]) begin
				b_c[c] = b_c[c] - 51'sd4294967296;
			end
		end
	end

	always_comb begin
		logic [61:0] sq;
		for (int k = 0; k < NL; k++) begin
			sq        = 62'(lg_m_s[k]) * 62'(lg_m_s[k]);
			lbit_c[k] = sq[61];
			lm_c[k]   = sq[61] ? sq[61:31] : sq[60:30];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NL; k++) begin
				lg_vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			lg_vld_s[0] <= vld_s1;
			for (int k = 0; k < NL; k++) begin
				lg_vld_s[k+1] <= lg_vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lg_inv_s[0] <= inv_s1;
			lg_j_s[0]   <= j_s1;
			lg_b_s[0]   <= b_c;
			lg_p_s[0]   <= p_s1;
			lg_m_s[0]   <= m_s1;
			lg_fr_s[0]  <= '0;
			for (int k = 0; k < NL; k++) begin
				lg_inv_s[k+1] <= lg_inv_s[k];
				lg_j_s[k+1]   <= lg_j_s[k];
				lg_b_s[k+1]   <= lg_b_s[k];
				lg_p_s[k+1]   <= lg_p_s[k];
				lg_m_s[k+1]   <= lm_c[k];
				lg_fr_s[k+1]  <= {lg_fr_s[k][22:0], lbit_c[k]};
			end
		end
	end

	// Stage 3: log2 J times ln 2, and partial products of mu times B.
	logic               vld_s3, inv_s3, lnneg_s3;
	logic [30:0]        j_s3;
	logic [60:0]        lnp_s3;
	logic [44:0]        tpp_s3 [6][4];
	logic               bneg_s3 [6];
	logic signed [29:0] l2_c;
	logic [28:0]        l2m_c;
	logic [44:0]        tpp_c [6][4];
	logic [49:0]        bm_c  [6];

	always_comb begin
		logic signed [5:0]  ex;
		logic signed [50:0] bneg;
		ex    = $signed({1'b0, lg_p_s[NL]}) - 6'sd24;
		l2_c  = {ex, lg_fr_s[NL]};
		l2m_c = l2_c < 0 ? 29'(-l2_c) : 29'(l2_c);
		for (int c = 0; c < 6; c++) begin
			bneg     = -lg_b_s[NL][c];
			bm_c[c]  = lg_b_s[NL][c] < 0 ? bneg[49:0] : lg_b_s[NL][c][49:0];
			tpp_c[c][0] = 45'(mu_q[19:0]) * 45'(bm_c[c][24:0]);
			tpp_c[c][1] = 45'(mu_q[19:0]) * 45'(bm_c[c][49:25]);
			tpp_c[c][2] = 45'(mu_q[39:20]) * 45'(bm_c[c][24:0]);
			tpp_c[c][3] = 45'(mu_q[39:20]) * 45'(bm_c[c][49:25]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= lg_vld_s[NL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s3   <= lg_inv_s[NL];
			j_s3     <= lg_j_s[NL];
			lnneg_s3 <= l2_c < 0;
			lnp_s3   <= 61'(l2m_c) * 61'(nhst_pkg::LN2_Q32);
			tpp_s3   <= tpp_c;
			for (int c = 0; c < 6; c++) begin
				bneg_s3[c] <= lg_b_s[NL][c] < 0;
			end
		end
	end

	// Stage 4: ln J, and mu times B summed and scaled.
	logic               vld_s4, inv_s4;
	logic [30:0]        j_s4;
	logic signed [29:0] lnj_s4;
	logic signed [58:0] taub_s4 [6];
	logic signed [58:0] taub_c  [6];

	always_comb begin
		logic [89:0] tot;
		for (int c = 0; c < 6; c++) begin
			tot = 90'(tpp_s3[c][0]) + (90'(tpp_s3[c][1]) << 25)
				+ (90'(tpp_s3[c][2]) << 20) + (90'(tpp_s3[c][3]) << 45);
			taub_c[c] = bneg_s3[c] ? -$signed({1'b0, tot[89:32]})
				: $signed({1'b0, tot[89:32]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s4  <= inv_s3;
			j_s4    <= j_s3;
			lnj_s4  <= lnneg_s3 ? -$signed({1'b0, lnp_s3[60:32]})
				: $signed({1'b0, lnp_s3[60:32]});
			taub_s4 <= taub_c;
		end
	end

	// Stage 5: partial products of lambda times ln J.
	logic               vld_s5, inv_s5, llneg_s5;
	logic [30:0]        j_s5;
	logic [48:0]        llp_lo_s5, llp_hi_s5;
	logic signed [58:0] taub_s5 [6];
	logic [28:0]        lnm_c;
	logic signed [29:0] lnn_c;

	assign lnn_c = -lnj_s4;
	assign lnm_c = lnj_s4 < 0 ? lnn_c[28:0] : lnj_s4[28:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s5    <= inv_s4;
			j_s5      <= j_s4;
			llneg_s5  <= lnj_s4 < 0;
			llp_lo_s5 <= 49'(lnm_c) * 49'(lam_q[19:0]);
			llp_hi_s5 <= 49'(lnm_c) * 49'(lam_q[39:20]);
			taub_s5   <= taub_s4;
		end
	end

	// Stage 6: lambda ln J and the tangent values.
	logic               vld_s6, inv_s6;
	logic [30:0]        j_s6;
	logic signed [45:0] ll_s6;
	logic [47:0]        tdiag_s6, tshear_s6;
	logic signed [58:0] taub_s6 [6];
	logic [68:0]        llt_c;
	logic signed [45:0] ll_c;
	logic signed [49:0] shear_c, diag_c;

	always_comb begin
		llt_c   = 69'(llp_lo_s5) + (69'(llp_hi_s5) << 20);
		ll_c    = llneg_s5 ? -$signed({1'b0, llt_c[68:24]}) : $signed({1'b0, llt_c[68:24]});
		shear_c = $signed(50'(mu_q)) - 50'(ll_c);
		diag_c  = $signed(50'(lam_q)) + (shear_c <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s6    <= inv_s5;
			j_s6      <= j_s5;
			ll_s6     <= ll_c;
			tdiag_s6  <= nhst_pkg::sat48(diag_c);
			tshear_s6 <= nhst_pkg::sat48(shear_c);
			taub_s6   <= taub_s5;
		end
	end

	// Stage 7 and the divider: tau, then one quotient bit per stage.
	logic        dv_vld_s [ND+1];
	logic        dv_inv_s [ND+1];
	logic [30:0] dv_j_s   [ND+1];
	logic [47:0] dv_td_s  [ND+1];
	logic [47:0] dv_ts_s  [ND+1];
	nhst_pkg::div_lane_t dv_ln_s [ND+1][6];
	nhst_pkg::div_lane_t init_c [6];
	nhst_pkg::div_lane_t step_c [ND][6];

	always_comb begin
		logic signed [59:0] tau;
		logic [59:0]        u;
		for (int c = 0; c < 6; c++) begin
			tau = 60'(taub_s6[c]);
			if (PI[c] == PJ[c]) begin
				tau = tau + 60'(ll_s6);
			end
			u = tau < 0 ? 60'(-tau) : 60'(tau);
			init_c[c].neg = tau < 0;
			init_c[c].ovf = u >= {5'b0, j_s6, 24'b0};
			init_c[c].rem = u[54:24];
			init_c[c].quo = '0;
			init_c[c].ulo = u[23:0];
		end
	end

	always_comb begin
		logic        bi;
		logic [31:0] t;
		for (int k = 0; k < ND; k++) begin
			for (int c = 0; c < 6; c++) begin
				bi = (k < 24) ? dv_ln_s[k][c].ulo[23-(k%24)] : 1'b0;
				t  = {dv_ln_s[k][c].rem, bi};
				step_c[k][c] = dv_ln_s[k][c];
				if (t >= {1'b0, dv_j_s[k]}) begin
					t = t - {1'b0, dv_j_s[k]};
					step_c[k][c].quo = {dv_ln_s[k][c].quo[46:0], 1'b1};
				end else begin
					step_c[k][c].quo = {dv_ln_s[k][c].quo[46:0], 1'b0};
				end
				step_c[k][c].rem = t[30:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= ND; k++) begin
				dv_vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			dv_vld_s[0] <= vld_s6;
			for (int k = 0; k < ND; k++) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_inv_s[0] <= inv_s6;
			dv_j_s[0]   <= j_s6;
			dv_td_s[0]  <= tdiag_s6;
			dv_ts_s[0]  <= tshear_s6;
			dv_ln_s[0]  <= init_c;
			for (int k = 0; k < ND; k++) begin
				dv_inv_s[k+1] <= dv_inv_s[k];
				dv_j_s[k+1]   <= dv_j_s[k];
				dv_td_s[k+1]  <= dv_td_s[k];
				dv_ts_s[k+1]  <= dv_ts_s[k];
				dv_ln_s[k+1]  <= step_c[k];
			end
		end
	end

	// Output register: sign, saturation and the invalid-determinant case.
	logic         out_vld_q;
	logic [391:0] out_q;
	logic [391:0] out_c;

	always_comb begin
		nhst_pkg::div_lane_t ln;
		out_c = '0;
		for (int c = 0; c < 6; c++) begin
			ln = dv_ln_s[ND][c];
			if (ln.ovf || ln.quo[47]) begin
				out_c[48*c +: 48] = ln.neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
			end else begin
				out_c[48*c +: 48] = ln.neg ? -ln.quo : ln.quo;
			end
		end
		out_c[288 +: 48] = dv_td_s[ND];
		out_c[336 +: 48] = dv_ts_s[ND];
		if (dv_inv_s[ND]) begin
			out_c        = '0;
			out_c[384]   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld_s[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_c;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

// ----- sv/nhst_checker.sv -----
// Port-level checks for the neo-Hookean stress block, bound to its top level.
module nhst_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [391:0] m_tdata
);

	// The input side is held only while a result waits.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow the output stall");

	// An invalid determinant zeroes every other field.
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[384]) |-> (m_tdata[383:0] == '0 && m_tdata[391:385] == '0))
		else $error("result fields not zero for invalid determinant");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	// Nothing leaves in the first cycle after reset.
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

endmodule

bind neo_hookean_stress_tangent nhst_checker u_nhst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
